/* rtl/core/hard_sphere_contact_force_2d_core_assert.svh */
// ----------------------------------------------------------------------------
// Contact force core assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HARD_SPHERE_CONTACT_FORCE_2D_CORE_ASSERT_SVH
`define HARD_SPHERE_CONTACT_FORCE_2D_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HSCF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("contact force core: implication failed");

// Implication with a fixed delay, disabled during reset.
`define HSCF_ASSERT_LAT(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("contact force core: delayed implication failed");

`endif

/* rtl/core/hscf_pkg.sv */
// ----------------------------------------------------------------------------
// Contact force core package
// Shared types, register codes, constants and the saturation function.
// ----------------------------------------------------------------------------
package hscf_pkg;

  localparam int unsigned HSCF_LATENCY = 7;

  typedef logic [0:0] reg_index_t;
  localparam reg_index_t REG_STIFFNESS = 1'b0;
  localparam reg_index_t REG_FRICTION  = 1'b1;

  localparam logic [30:0] STIFFNESS_RESET = 31'd65536;
  localparam logic [15:0] FRICTION_RESET  = 16'd6554;

  typedef enum logic [1:0] {
    SGN_ZERO,
    SGN_POS,
    SGN_NEG
  } sgn_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] fn;
    sgn_t               sgn;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [30:0]        ra;
    logic [30:0]        rb;
  } front_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] fn;
    logic signed [32:0] fs;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [30:0]        ra;
    logic [30:0]        rb;
  } fric_t;

  localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
  localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (x < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(x[31:0]);
    end
    return r;
  endfunction

endpackage

/* rtl/core/hard_sphere_contact_force_2d_core.sv */
// A request accepted at a clock edge shows its result on done after the front, friction and output stages.
// Throughput: one contact pair per cycle, set by seven register stages around the multipliers.
// The receiver cannot stall, so busy is high only while rst is high.
// Reset clears all stage valid bits and loads stiffness 1.0 and friction about 0.1.
// ----------------------------------------------------------------------------
// Hard sphere contact force core
// Linear spring normal force with Coulomb friction for one disc pair in 2D.
// ----------------------------------------------------------------------------
module hard_sphere_contact_force_2d_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [31:0]      normal_x,
  input  logic signed [31:0]      normal_y,
  input  logic [30:0]             distance,
  input  logic [30:0]             radius_a,
  input  logic [30:0]             radius_b,
  input  logic signed [31:0]      vel_a_x,
  input  logic signed [31:0]      vel_a_y,
  input  logic signed [31:0]      vel_b_x,
  input  logic signed [31:0]      vel_b_y,
  input  logic signed [31:0]      spin_a,
  input  logic signed [31:0]      spin_b,
  input  logic                    cfg_we,
  input  hscf_pkg::reg_index_t    cfg_index,
  input  logic [30:0]             cfg_data,
  output logic                    done,
  output logic signed [31:0]      force_x,
  output logic signed [31:0]      force_y,
  output logic signed [31:0]      torque_a,
  output logic signed [31:0]      torque_b,
  output logic signed [31:0]      normal_force
);
  import hscf_pkg::*;

  logic [30:0] stiffness;
  logic [15:0] friction_coeff;
  logic        accept;
  front_t      front;
  fric_t       fric;

  assign busy = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= STIFFNESS_RESET;
      friction_coeff <= FRICTION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STIFFNESS: stiffness <= cfg_data;
        REG_FRICTION:  friction_coeff <= cfg_data[15:0];
      endcase
    end
  end

  hscf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .distance  (distance),
    .radius_a  (radius_a),
    .radius_b  (radius_b),
    .vel_a_x   (vel_a_x),
    .vel_a_y   (vel_a_y),
    .vel_b_x   (vel_b_x),
    .vel_b_y   (vel_b_y),
    .spin_a    (spin_a),
    .spin_b    (spin_b),
    .stiffness (stiffness),
    .fo        (front)
  );

  hscf_friction u_friction (
    .clk            (clk),
    .rst            (rst),
    .fi             (front),
    .friction_coeff (friction_coeff),
    .fo             (fric)
  );

  hscf_output u_output (
    .clk          (clk),
    .rst          (rst),
    .fi           (fric),
    .done         (done),
    .force_x      (force_x),
    .force_y      (force_y),
    .torque_a     (torque_a),
    .torque_b     (torque_b),
    .normal_force (normal_force)
  );

endmodule

/* rtl/core/hscf_front.sv */
// ----------------------------------------------------------------------------
// Contact force front stages
// Overlap, spring force and exact sign of the shear velocity over three stages.
// ----------------------------------------------------------------------------
module hscf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic [30:0]        distance,
  input  logic [30:0]        radius_a,
  input  logic [30:0]        radius_b,
  input  logic signed [31:0] vel_a_x,
  input  logic signed [31:0] vel_a_y,
  input  logic signed [31:0] vel_b_x,
  input  logic signed [31:0] vel_b_y,
  input  logic signed [31:0] spin_a,
  input  logic signed [31:0] spin_b,
  input  logic [30:0]        stiffness,
  output hscf_pkg::front_t   fo
);
  import hscf_pkg::*;

  logic               v1;
  logic signed [33:0] ov1;
  logic signed [63:0] p1 [6];
  logic signed [31:0] nx1, ny1;
  logic [30:0]        ra1, rb1;

  logic               v2;
  logic signed [65:0] kov2;
  logic signed [65:0] sa2, sb2;
  logic signed [31:0] nx2, ny2;
  logic [30:0]        ra2, rb2;

  logic signed [33:0] ov;
  logic signed [31:0] ra_s, rb_s;
  logic signed [66:0] vs;

  assign ra_s = $signed({1'b0, radius_a});
  assign rb_s = $signed({1'b0, radius_b});
  assign ov = $signed({3'b000, radius_a}) + $signed({3'b000, radius_b})
            - $signed({3'b000, distance});
  assign vs = 67'(sa2) + 67'(sb2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      fo.valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      fo.valid <= v2;
    end

    ov1 <= ov;
    p1[0] <= vel_b_x * normal_y;
    p1[1] <= vel_a_x * normal_y;
    p1[2] <= vel_b_y * normal_x;
    p1[3] <= vel_a_y * normal_x;
    p1[4] <= ra_s * spin_a;
    p1[5] <= rb_s * spin_b;
    nx1 <= normal_x;
    ny1 <= normal_y;
    ra1 <= radius_a;
    rb1 <= radius_b;

    kov2 <= $signed({1'b0, stiffness}) * ov1;
    sa2 <= 66'(p1[0]) - 66'(p1[1]) - 66'(p1[2]);
    sb2 <= 66'(p1[3]) + 66'(p1[4]) + 66'(p1[5]);
    nx2 <= nx1;
    ny2 <= ny1;
    ra2 <= ra1;
    rb2 <= rb1;

    fo.fn <= sat32(68'(kov2 >>> 16));
    if (vs > 67'sd0) begin
      fo.sgn <= SGN_POS;
    end else if (vs < 67'sd0) begin
      fo.sgn <= SGN_NEG;
    end else begin
      fo.sgn <= SGN_ZERO;
    end
    fo.nx <= nx2;
    fo.ny <= ny2;
    fo.ra <= ra2;
    fo.rb <= rb2;
  end

endmodule

/* rtl/core/hscf_friction.sv */
// ----------------------------------------------------------------------------
// Contact force friction stages
// Coulomb shear force magnitude and its sign over two stages.
// ----------------------------------------------------------------------------
module hscf_friction (
  input  logic             clk,
  input  logic             rst,
  input  hscf_pkg::front_t fi,
  input  logic [15:0]      friction_coeff,
  output hscf_pkg::fric_t  fo
);
  import hscf_pkg::*;

  logic               v4;
  logic signed [48:0] fm4;
  logic signed [31:0] fn4, nx4, ny4;
  sgn_t               sgn4;
  logic [30:0]        ra4, rb4;

  logic signed [48:0] fsh;
  logic signed [32:0] fmag;
  logic signed [32:0] fs;

  assign fsh = fm4 >>> 16;
  assign fmag = fsh[32:0];

  always_comb begin
    unique case (sgn4)
      SGN_POS: fs = fmag;
      SGN_NEG: fs = -fmag;
      default: fs = 33'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      fo.valid <= 1'b0;
    end else begin
      v4 <= fi.valid;
      fo.valid <= v4;
    end

    fm4 <= $signed({1'b0, friction_coeff}) * fi.fn;
    fn4 <= fi.fn;
    sgn4 <= fi.sgn;
    nx4 <= fi.nx;
    ny4 <= fi.ny;
    ra4 <= fi.ra;
    rb4 <= fi.rb;

    fo.fn <= fn4;
    fo.fs <= fs;
    fo.nx <= nx4;
    fo.ny <= ny4;
    fo.ra <= ra4;
    fo.rb <= rb4;
  end

endmodule

/* rtl/core/hscf_output.sv */
// ----------------------------------------------------------------------------
// Contact force output stages
// Force vector and torque products, rescale and saturation over two stages.
// ----------------------------------------------------------------------------
module hscf_output (
  input  logic               clk,
  input  logic               rst,
  input  hscf_pkg::fric_t    fi,
  output logic               done,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] torque_a,
  output logic signed [31:0] torque_b,
  output logic signed [31:0] normal_force
);
  import hscf_pkg::*;

  logic               v6;
  logic signed [63:0] pxn6, pyn6;
  logic signed [64:0] pxs6, pys6;
  logic signed [64:0] pta6, ptb6;
  logic signed [31:0] fn6;

  logic signed [65:0] sx, sy;
  logic signed [64:0] nta, ntb;

  assign sx = 66'(pxn6) + 66'(pxs6);
  assign sy = 66'(pyn6) - 66'(pys6);
  assign nta = -pta6;
  assign ntb = -ptb6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      done <= 1'b0;
    end else begin
      v6 <= fi.valid;
      done <= v6;
    end

    pxn6 <= fi.fn * fi.nx;
    pyn6 <= fi.fn * fi.ny;
    pxs6 <= fi.fs * fi.ny;
    pys6 <= fi.fs * fi.nx;
    pta6 <= $signed({1'b0, fi.ra}) * fi.fs;
    ptb6 <= $signed({1'b0, fi.rb}) * fi.fs;
    fn6 <= fi.fn;

    force_x <= sat32(68'(sx >>> 16));
    force_y <= sat32(68'(sy >>> 16));
    torque_a <= sat32(68'(nta >>> 16));
    torque_b <= sat32(68'(ntb >>> 16));
    normal_force <= fn6;
  end

endmodule

/* rtl/core/hscf_checker.sv */
// ----------------------------------------------------------------------------
// Contact force core port checker
// Latency, result origin and force consistency as seen on the top level ports.
// ----------------------------------------------------------------------------
`include "hard_sphere_contact_force_2d_core_assert.svh"

module hscf_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] force_x,
  input logic signed [31:0] force_y,
  input logic signed [31:0] torque_a,
  input logic signed [31:0] torque_b,
  input logic signed [31:0] normal_force
);
  import hscf_pkg::*;

  localparam int unsigned LAT = HSCF_LATENCY;

  // Every accepted request yields a result after the fixed latency.
  `HSCF_ASSERT_LAT(a_latency, clk, rst, start && !busy, LAT, done)

  // No result appears without a request accepted the same latency earlier.
  `HSCF_ASSERT_IMPL(a_origin, clk, rst, done, $past(start && !busy, LAT))

  // A zero normal force leaves no shear, so all force and torque outputs are zero.
  `HSCF_ASSERT_IMPL(a_zero_fn, clk, rst, done && normal_force == 32'sd0, force_x == 32'sd0 && force_y == 32'sd0 && torque_a == 32'sd0 && torque_b == 32'sd0)

  // Both torques come from the same shear force and nonnegative radii.
  `HSCF_ASSERT_IMPL(a_torque_sign, clk, rst, done, !((torque_a > 32'sd0 && torque_b < 32'sd0) || (torque_a < 32'sd0 && torque_b > 32'sd0)))

endmodule

bind hard_sphere_contact_force_2d_core hscf_checker u_hscf_checker (.*);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Contact force core testbench
// Streams contact pairs into the core and checks every result against a
// bit-exact model of the spring and friction arithmetic or a pinned value.
// A short table of directed pairs runs first, then random pairs under
// several register settings and request idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import hscf_pkg::*;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [30:0]        cdist;
    logic [30:0]        ra;
    logic [30:0]        rb;
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [31:0] wa;
    logic signed [31:0] wb;
  } contact_req_t;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] ta;
    logic signed [31:0] tb;
    logic signed [31:0] fn;
  } contact_res_t;

  typedef struct {
    contact_req_t req;
    bit           pinned;
    contact_res_t res;
  } stim_row_t;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;
  localparam logic [30:0]        U_MAX = 31'h7fffffff;
  localparam int                 PHASE_ITEMS = 150;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic         cfg_we = 1'b0;
  reg_index_t   cfg_index = REG_STIFFNESS;
  logic [30:0]  cfg_data = '0;
  contact_req_t req_drv = '0;
  logic         pin_exp = 1'b0;
  contact_res_t pin_res = '0;

  logic               busy;
  logic               done;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] torque_a;
  logic signed [31:0] torque_b;
  logic signed [31:0] normal_force;

  logic [30:0]  stiffness_q;
  logic [15:0]  friction_q;
  contact_res_t pending_forces[$];
  stim_row_t    stim_rows[$];
  int           mismatches = 0;

  always #2 clk = ~clk;

  hard_sphere_contact_force_2d_core u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .normal_x    (req_drv.nx),
    .normal_y    (req_drv.ny),
    .distance    (req_drv.cdist),
    .radius_a    (req_drv.ra),
    .radius_b    (req_drv.rb),
    .vel_a_x     (req_drv.vax),
    .vel_a_y     (req_drv.vay),
    .vel_b_x     (req_drv.vbx),
    .vel_b_y     (req_drv.vby),
    .spin_a      (req_drv.wa),
    .spin_b      (req_drv.wb),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .force_x     (force_x),
    .force_y     (force_y),
    .torque_a    (torque_a),
    .torque_b    (torque_b),
    .normal_force(normal_force)
  );

  function automatic logic signed [31:0] clamp32(input logic signed [79:0] x);
    if (x > 80'sd2147483647) begin
      return S_MAX;
    end
    if (x < -80'sd2147483648) begin
      return S_MIN;
    end
    return x[31:0];
  endfunction

  function automatic contact_res_t contact_force(input contact_req_t q,
                                                 input logic [30:0] k,
                                                 input logic [15:0] mu);
    logic signed [79:0] n_x, n_y, r_a, r_b, d, v_ax, v_ay, v_bx, v_by, w_a, w_b;
    logic signed [79:0] kk, mm, fn, vs, fmag, fs;
    contact_res_t r;
    n_x  = {{48{q.nx[31]}}, q.nx};
    n_y  = {{48{q.ny[31]}}, q.ny};
    v_ax = {{48{q.vax[31]}}, q.vax};
    v_ay = {{48{q.vay[31]}}, q.vay};
    v_bx = {{48{q.vbx[31]}}, q.vbx};
    v_by = {{48{q.vby[31]}}, q.vby};
    w_a  = {{48{q.wa[31]}}, q.wa};
    w_b  = {{48{q.wb[31]}}, q.wb};
    r_a  = {49'd0, q.ra};
    r_b  = {49'd0, q.rb};
    d    = {49'd0, q.cdist};
    kk   = {49'd0, k};
    mm   = {64'd0, mu};
    fn   = clamp32((kk * (r_a + r_b - d)) >>> 16);
    vs   = v_bx * n_y - v_ax * n_y - v_by * n_x + v_ay * n_x + r_a * w_a + r_b * w_b;
    fmag = (mm * fn) >>> 16;
    fs   = (vs > 0) ? fmag : ((vs < 0) ? -fmag : 80'sd0);
    r.fx = clamp32((fn * n_x + fs * n_y) >>> 16);
    r.fy = clamp32((fn * n_y - fs * n_x) >>> 16);
    r.ta = clamp32((-(r_a * fs)) >>> 16);
    r.tb = clamp32((-(r_b * fs)) >>> 16);
    r.fn = fn[31:0];
    return r;
  endfunction

  function automatic int rnd_span(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic contact_req_t gen_pair();
    contact_req_t q;
    int sx, sy;
    q = '0;
    if ($urandom_range(0, 9) < 3) begin
      q.nx    = $urandom;
      q.ny    = $urandom;
      q.cdist = 31'($urandom);
      q.ra    = 31'($urandom);
      q.rb    = 31'($urandom);
      q.vax   = $urandom;
      q.vay   = $urandom;
      q.vbx   = $urandom;
      q.vby   = $urandom;
      q.wa    = $urandom;
      q.wb    = $urandom;
      return q;
    end
    sx = $urandom_range(0, 1) ? 1 : -1;
    sy = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 3))
      0: begin
        q.nx = sx * 65536;
      end
      1: begin
        q.ny = sy * 65536;
      end
      2: begin
        q.nx = sx * 39322;
        q.ny = sy * 52429;
      end
      default: begin
        q.nx = rnd_span(65536);
        q.ny = rnd_span(65536);
      end
    endcase
    q.ra = 31'($urandom_range(6554, 262144));
    q.rb = 31'($urandom_range(6554, 262144));
    case ($urandom_range(0, 7))
      0: begin
        q.cdist = q.ra + q.rb;
      end
      1: begin
        q.cdist = q.ra + q.rb + 31'($urandom_range(1, 6000));
      end
      default: begin
        q.cdist = q.ra + q.rb - 31'($urandom_range(0, 6000));
      end
    endcase
    if ($urandom_range(0, 7) != 0) begin
      q.vax = rnd_span(1 << 20);
      q.vay = rnd_span(1 << 20);
      q.vbx = rnd_span(1 << 20);
      q.vby = rnd_span(1 << 20);
      q.wa  = rnd_span(1 << 18);
      q.wb  = rnd_span(1 << 18);
    end
    return q;
  endfunction

  task automatic add_row(input logic signed [31:0] nx, ny, input logic [30:0] cdist, ra, rb,
                         input logic signed [31:0] vax, vay, vbx, vby, wa, wb,
                         input bit pinned, input contact_res_t res);
    stim_row_t row;
    row.req    = {nx, ny, cdist, ra, rb, vax, vay, vbx, vby, wa, wb};
    row.pinned = pinned;
    row.res    = res;
    stim_rows.push_back(row);
  endtask

  task automatic send_pair(input contact_req_t q, input bit pinned, input contact_res_t res,
                           input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    req_drv <= q;
    pin_exp <= pinned;
    pin_res <= res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic settle();
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (HSCF_LATENCY + 2) @(posedge clk);
  endtask

  task automatic cmp_field(input string name, input logic signed [31:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    contact_res_t want;
    if (rst) begin
      stiffness_q <= STIFFNESS_RESET;
      friction_q  <= FRICTION_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STIFFNESS: stiffness_q <= cfg_data;
          REG_FRICTION:  friction_q  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        pending_forces.push_back(pin_exp ? pin_res
                                 : contact_force(req_drv, stiffness_q, friction_q));
      end
      if (done) begin
        if (pending_forces.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %0d %0d %0d %0d %0d",
                   $time, force_x, force_y, torque_a, torque_b, normal_force);
          mismatches++;
        end else begin
          want = pending_forces.pop_front();
          cmp_field("force_x", want.fx, force_x);
          cmp_field("force_y", want.fy, force_y);
          cmp_field("torque_a", want.ta, torque_a);
          cmp_field("torque_b", want.tb, torque_b);
          cmp_field("normal_force", want.fn, normal_force);
        end
      end
    end
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int idle_pct;
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, '0);
    add_row(0, 0, 0, U_MAX, U_MAX, 0, 0, 0, 0, 0, 0, 1'b1,
            {32'sd0, 32'sd0, 32'sd0, 32'sd0, S_MAX});
    add_row(0, 0, U_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1,
            {32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sh80000001});
    add_row(Q_ONE, 0, 131072, Q_ONE, Q_ONE, 3 * Q_ONE, 0, 0, -Q_ONE, Q_ONE, 0, 1'b1, '0);
    add_row(Q_ONE, 0, 98304, Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(0, Q_ONE, 98304, Q_ONE, Q_ONE, 0, 0, Q_ONE, 0, 0, 0, 1'b0, '0);
    add_row(0, Q_ONE, 98304, Q_ONE, Q_ONE, 0, 0, -Q_ONE, 0, 0, 0, 1'b0, '0);
    add_row(Q_ONE, 0, 98304, Q_ONE, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 1'b0, '0);
    add_row(-Q_ONE, 0, 98304, Q_ONE, 2 * Q_ONE, 0, 0, 0, 0, 0, -Q_ONE, 1'b0, '0);
    add_row(0, 1, Q_ONE, Q_ONE, Q_ONE, 0, 0, 1, 0, 0, 0, 1'b0, '0);
    add_row(0, 1, Q_ONE, Q_ONE, Q_ONE, 1, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(0, Q_ONE, 98304, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, Q_ONE, 0, 1'b0, '0);
    add_row(0, Q_ONE, 98304, Q_ONE, Q_ONE, 12345, 0, 12345, 0, 0, 0, 1'b0, '0);
    add_row(2 * Q_ONE, 3 * Q_ONE, 98304, Q_ONE, Q_ONE, 0, Q_ONE, Q_ONE, 0, 0, 0, 1'b0, '0);
    add_row(0, Q_ONE, 3 * Q_ONE, Q_ONE, Q_ONE, 0, 0, Q_ONE, 0, 0, 0, 1'b0, '0);
    add_row(S_MIN, S_MIN, 0, U_MAX, U_MAX, S_MAX, S_MIN, S_MIN, S_MAX, S_MIN, S_MIN,
            1'b0, '0);
    add_row(S_MAX, S_MAX, 0, U_MAX, U_MAX, S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX,
            1'b0, '0);
    add_row(-1, -1, U_MAX, U_MAX, U_MAX, -1, -1, -1, -1, -1, -1, 1'b0, '0);
    add_row(S_MIN, S_MAX, 1, U_MAX, 0, S_MAX, S_MAX, S_MIN, S_MIN, S_MAX, S_MIN, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      send_pair(stim_rows[i].req, stim_rows[i].pinned, stim_rows[i].res, 34);
    end
    start <= 1'b0;
    settle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          write_reg(REG_STIFFNESS, U_MAX);
          write_reg(REG_FRICTION, U_MAX);
        end
        1: begin
          write_reg(REG_STIFFNESS, '0);
          write_reg(REG_FRICTION, '0);
        end
        2: begin
          write_reg(REG_STIFFNESS, 31'($urandom_range(0, 1 << 20)));
          write_reg(REG_FRICTION, 31'($urandom) | 31'h0000ffff);
        end
        3: begin
          write_reg(REG_STIFFNESS, U_MAX);
          write_reg(REG_FRICTION, 31'($urandom) & 31'h7fff0000);
        end
        default: begin
          write_reg(REG_STIFFNESS, $urandom_range(0, 1) ? 31'($urandom)
                                                        : 31'($urandom_range(0, 1 << 21)));
          write_reg(REG_FRICTION, 31'($urandom));
        end
      endcase
      cfg_we <= 1'b0;
      idle_pct = (p < 2) ? 34 : ((p < 4) ? 50 : 0);
      repeat (PHASE_ITEMS) begin
        send_pair(gen_pair(), 1'b0, '0, idle_pct);
      end
      start <= 1'b0;
      settle();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
